// ===== rtl/core/kdem_pkg.sv =====
// Package for the keypad debounce and event mapper: types, codes and key mapping.
package kdem_pkg;

   typedef logic [3:0] key_idx_type;
   typedef logic [4:0] cand_type;
   typedef logic [3:0] key_role_type;

   localparam cand_type  NoKey         = 5'd16;
   localparam logic [7:0] DebounceReset = 8'd20;

   // key functions above the digits
   localparam key_role_type FnMode   = 4'd10;
   localparam key_role_type FnSet    = 4'd11;
   localparam key_role_type FnEnter  = 4'd12;
   localparam key_role_type FnInc    = 4'd13;
   localparam key_role_type FnDec    = 4'd14;
   localparam key_role_type FnCancel = 4'd15;
   localparam key_role_type LastDigit = 4'd9;

   // system modes
   localparam logic [2:0] ModeClock     = 3'd0;
   localparam logic [2:0] ModeMenu      = 3'd1;
   localparam logic [2:0] ModeNumber    = 3'd2;
   localparam logic [2:0] ModeStopwatch = 3'd3;

   // event codes
   localparam logic [3:0] EvMenuSelect = 4'd0;
   localparam logic [3:0] EvNumber     = 4'd1;
   localparam logic [3:0] EvModeChange = 4'd2;
   localparam logic [3:0] EvSet        = 4'd3;
   localparam logic [3:0] EvInc        = 4'd4;
   localparam logic [3:0] EvDec        = 4'd5;
   localparam logic [3:0] EvSwToggle   = 4'd6;
   localparam logic [3:0] EvEnter      = 4'd7;
   localparam logic [3:0] EvSwReset    = 4'd8;
   localparam logic [3:0] EvDispUpdate = 4'd9;
   localparam logic [3:0] EvCancel     = 4'd10;

   typedef struct packed {
      logic [3:0] event_code;
      logic [3:0] event_arg;
      logic [2:0] event_mode;
      logic       last_of_run;
   } event_type;

   typedef struct packed {
      logic      two;
      event_type first;
      event_type second;
   } event_pair_type;

   function automatic key_role_type key_role(input key_idx_type key);
      key_role_type f;
      case (key)
         4'd0:    f = 4'd7;
         4'd1:    f = 4'd8;
         4'd2:    f = 4'd9;
         4'd3:    f = FnMode;
         4'd4:    f = 4'd4;
         4'd5:    f = 4'd5;
         4'd6:    f = 4'd6;
         4'd7:    f = FnSet;
         4'd8:    f = 4'd1;
         4'd9:    f = 4'd2;
         4'd10:   f = 4'd3;
         4'd11:   f = FnEnter;
         4'd12:   f = 4'd0;
         4'd13:   f = FnInc;
         4'd14:   f = FnDec;
         default: f = FnCancel;
      endcase
      return f;
   endfunction

   function automatic event_pair_type map_events(input key_idx_type key,
                                                 input logic [2:0] mode);
      event_pair_type p;
      key_role_type   f;
      f = key_role(key);
      p.two = 1'b0;
      p.first.event_code  = EvCancel;
      p.first.event_arg   = 4'd0;
      p.first.event_mode  = mode;
      p.first.last_of_run = 1'b1;
      p.second.event_code  = EvDispUpdate;
      p.second.event_arg   = 4'd0;
      p.second.event_mode  = mode;
      p.second.last_of_run = 1'b1;
      if (f <= LastDigit) begin
         p.first.event_code = (mode == ModeMenu) ? EvMenuSelect : EvNumber;
         p.first.event_arg  = f;
      end else begin
         case (f)
            FnMode: begin
               p.first.event_code = EvModeChange;
               p.first.event_arg  = (mode == ModeClock) ? 4'(ModeMenu) : 4'(ModeClock);
            end
            FnSet: begin
               if (mode == ModeClock) begin
                  p.first.event_code = EvModeChange;
                  p.first.event_arg  = 4'(ModeNumber);
               end else begin
                  p.first.event_code = EvSet;
               end
            end
            FnInc:   p.first.event_code = EvInc;
            FnDec:   p.first.event_code = EvDec;
            FnEnter: p.first.event_code = (mode == ModeStopwatch) ? EvSwToggle : EvEnter;
            default: begin
               if (mode == ModeStopwatch) begin
                  p.two               = 1'b1;
                  p.first.event_code  = EvSwReset;
                  p.first.last_of_run = 1'b0;
               end
            end
         endcase
      end
      return p;
   endfunction

endpackage

// ===== rtl/core/kdem_if.sv =====
// Channel interfaces for the keypad debounce and event mapper.
interface kdem_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] key_lines;
   logic [31:0] now_ms;
   logic [2:0]  sys_mode;
   modport source (output valid, key_lines, now_ms, sys_mode, input ready);
   modport sink (input valid, key_lines, now_ms, sys_mode, output ready);
endinterface

interface kdem_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_code;
   logic [3:0] event_arg;
   logic [2:0] event_mode;
   logic       last_of_run;
   modport source (output valid, event_code, event_arg, event_mode, last_of_run,
                   input ready);
   modport sink (input valid, event_code, event_arg, event_mode, last_of_run,
                 output ready);
endinterface

interface kdem_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] debounce_ms;
   modport source (output valid, debounce_ms, input ready);
   modport sink (input valid, debounce_ms, output ready);
endinterface

// ===== rtl/core/keypad_debounce_event_mapper.sv =====
// Keypad debounce and event mapper top level.
//  channel | dir | payload                                        | transaction
//  req     | in  | key_lines, now_ms, sys_mode                    | valid & ready
//  rsp     | out | event_code, event_arg, event_mode, last_of_run | valid & ready
//  csr     | in  | debounce_ms                                    | valid & ready
// One poll per cycle while req.ready is high; state updates at the edge that accepts the transaction.
// Events go to a three-entry output queue; into an empty queue, the first shows on rsp the next cycle.
// A stopwatch cancel adds two events, the second queued behind the first.
// req.ready is low while the queue holds two or more events; csr.ready is always high.
// Synchronous reset clears the latch, candidate, queue count and sets debounce to 20.
module keypad_debounce_event_mapper (
   input logic         clock,
   input logic         reset,
   kdem_req_if.sink    req,
   kdem_rsp_if.source  rsp,
   kdem_csr_if.sink    csr
);

   logic [7:0]  debounce_ff;
   logic        latched_ff, latched_in;
   logic [4:0]  cand_ff, cand_in;
   logic [31:0] since_ff, since_in;
   kdem_pkg::event_type q_ff [3];
   kdem_pkg::event_type q_in [3];
   kdem_pkg::event_type shifted [3];
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept, pop, found, fire;
   logic [3:0]  key_idx;
   logic [31:0] elapsed;
   logic [1:0]  base, push_n;
   kdem_pkg::event_pair_type pair;

   assign accept = req.valid && req.ready;
   assign pop    = rsp.valid && rsp.ready;

   always_comb begin
      found   = 1'b0;
      key_idx = 4'd0;
      for (int i = 15; i >= 0; i--) begin
         if (req.key_lines[i]) begin
            found   = 1'b1;
            key_idx = 4'(i);
         end
      end
   end

   assign elapsed = req.now_ms - since_ff;
   assign fire    = found && !latched_ff && (cand_ff == {1'b0, key_idx})
                    && (elapsed >= {24'd0, debounce_ff});
   assign pair    = kdem_pkg::map_events(key_idx, req.sys_mode);

   always_comb begin
      latched_in = latched_ff;
      cand_in    = cand_ff;
      since_in   = since_ff;
      if (accept) begin
         if (!found) begin
            latched_in = 1'b0;
            cand_in    = kdem_pkg::NoKey;
         end else if (latched_ff) begin
            since_in = req.now_ms;
         end else if (cand_ff != {1'b0, key_idx}) begin
            since_in = req.now_ms;
            cand_in  = {1'b0, key_idx};
         end else if (fire) begin
            latched_in = 1'b1;
         end
      end
   end

   always_comb begin
      push_n = (accept && fire) ? (pair.two ? 2'd2 : 2'd1) : 2'd0;
      base   = cnt_ff - {1'b0, pop};
      if (pop) begin
         shifted[0] = q_ff[1];
         shifted[1] = q_ff[2];
         shifted[2] = q_ff[2];
      end else begin
         shifted[0] = q_ff[0];
         shifted[1] = q_ff[1];
         shifted[2] = q_ff[2];
      end
      for (int i = 0; i < 3; i++) begin
         q_in[i] = shifted[i];
         if (push_n != 2'd0 && base == 2'(i))
            q_in[i] = pair.first;
         if (push_n == 2'd2 && (base + 2'd1) == 2'(i))
            q_in[i] = pair.second;
      end
      cnt_in = base + push_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= kdem_pkg::DebounceReset;
         latched_ff  <= 1'b0;
         cand_ff     <= kdem_pkg::NoKey;
         since_ff    <= 32'd0;
         cnt_ff      <= 2'd0;
      end else begin
         if (csr.valid && csr.ready)
            debounce_ff <= csr.debounce_ms;
         latched_ff <= latched_in;
         cand_ff    <= cand_in;
         since_ff   <= since_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign req.ready       = !cnt_ff[1];
   assign csr.ready       = 1'b1;
   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.event_code  = q_ff[0].event_code;
   assign rsp.event_arg   = q_ff[0].event_arg;
   assign rsp.event_mode  = q_ff[0].event_mode;
   assign rsp.last_of_run = q_ff[0].last_of_run;

`ifndef SYNTHESIS
   a_fire_latches: assert property (@(posedge clock) disable iff (reset)
      accept && fire |=> latched_ff)
      else $error("accepted press did not latch");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      accept && !found |=> !latched_ff && cand_ff == kdem_pkg::NoKey)
      else $error("release did not clear latch and candidate");

   a_pair_queued: assert property (@(posedge clock) disable iff (reset)
      accept && fire && pair.two |=> cnt_ff >= 2'd2)
      else $error("two-event press not queued");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      pop && !accept |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("queue count wrong after pop");
`endif

endmodule
